### rtl/core/spb_pkg.sv
// Shared definitions for the sprite page blitter: defaults, codes and the command record.
// Used by spb_queue, spb_front, spb_back and the top level; depends on nothing.
package spb_pkg;

  localparam int FB_WIDTH_DEF  = 128;
  localparam int FB_HEIGHT_DEF = 64;
  // Widest framebuffer address over the supported geometry range.
  localparam int ADDR_W_MAX    = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] MODE_XOR  = 2'd0;
  localparam logic [1:0] MODE_OR   = 2'd1;
  localparam logic [1:0] MODE_CLR  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic REG_SHIFT_X = 1'b0;
  localparam logic REG_SHIFT_Y = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } spb_state_t;

  typedef struct packed {
    logic                  is_read;
    logic                  rd_zero;
    logic                  en0;
    logic                  en1;
    logic [1:0]            mode;
    logic [7:0]            bits0;
    logic [7:0]            bits1;
    logic [ADDR_W_MAX-1:0] addr0;
    logic [ADDR_W_MAX-1:0] addr1;
  } spb_cmd_t;

endpackage

### rtl/core/spb_in_if.sv
// Input channel of the sprite page blitter: valid/ready handshake and item fields.
// Depends on nothing.
interface spb_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         width;
  logic [7:0]         height;
  logic [1:0]         mode;
  logic               flip_x;
  logic [4:0]         sprite_row;
  logic [7:0]         sprite_col;
  logic [7:0]         sprite_byte;
  logic [9:0]         read_addr;

  modport source (
    output valid, op, pos_x, pos_y, width, height, mode, flip_x,
    output sprite_row, sprite_col, sprite_byte, read_addr,
    input  ready
  );
  modport sink (
    input  valid, op, pos_x, pos_y, width, height, mode, flip_x,
    input  sprite_row, sprite_col, sprite_byte, read_addr,
    output ready
  );
endinterface

### rtl/core/spb_out_if.sv
// Result channel of the sprite page blitter: valid/ready handshake and the read byte.
// Depends on nothing.
interface spb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

### rtl/core/spb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module spb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/spb_queue.sv
// Short command queue between the front classifier and the back memory engine.
// Depends on spb_pkg.
module spb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spb_pkg::spb_cmd_t push_cmd,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output spb_pkg::spb_cmd_t head_cmd
);

  localparam int QD = spb_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  spb_pkg::spb_cmd_t entries [QD];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CW'(QD));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && push_ready && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

### rtl/core/spb_front.sv
// Front end: takes items, translates and clips sprite bytes and turns them into memory commands.
// Depends on spb_pkg and spb_in_if; feeds spb_queue.
module spb_front #(
  parameter int FB_WIDTH  = spb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = spb_pkg::FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  spb_in_if.sink             in_ch,
  input  logic               run,
  input  logic signed [15:0] shift_x,
  input  logic signed [15:0] shift_y,
  input  logic               q_ready,
  output logic               q_push,
  output spb_pkg::spb_cmd_t  q_cmd
);

  localparam int FB_PAGES = FB_HEIGHT / 8;
  localparam int FB_BYTES = FB_WIDTH * FB_PAGES;
  localparam int AMW      = spb_pkg::ADDR_W_MAX;
  localparam logic signed [17:0] XMAX = 18'(FB_WIDTH - 1);
  localparam logic signed [17:0] YMAX = 18'(FB_HEIGHT - 1);
  localparam logic signed [13:0] PMAX = 14'(FB_PAGES - 1);

  logic               s1_valid;
  logic               s1_op;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic [7:0]         s1_w;
  logic [7:0]         s1_h;
  logic [1:0]         s1_mode;
  logic               s1_flip;
  logic [4:0]         s1_row;
  logic [7:0]         s1_col;
  logic [7:0]         s1_bits;
  logic [9:0]         s1_raddr;

  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic signed [17:0] w18;
  logic signed [17:0] h18;
  logic signed [17:0] c18;
  logic signed [17:0] xw;
  logic signed [17:0] yh;
  logic signed [17:0] col;
  logic signed [13:0] page;
  logic [2:0]         off;
  logic               en0;
  logic               en1;
  logic               drop;
  logic               s1_leave;
  int                 page_i;
  int                 col_i;

  assign s1_leave    = drop || q_ready;
  assign in_ch.ready = run && (!s1_valid || s1_leave);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end else if (s1_leave) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op    <= in_ch.op;
      s1_x     <= in_ch.pos_x + shift_x;
      s1_y     <= in_ch.pos_y + shift_y;
      s1_w     <= in_ch.width;
      s1_h     <= in_ch.height;
      s1_mode  <= in_ch.mode;
      s1_flip  <= in_ch.flip_x;
      s1_row   <= in_ch.sprite_row;
      s1_col   <= in_ch.sprite_col;
      s1_bits  <= in_ch.sprite_byte;
      s1_raddr <= in_ch.read_addr;
    end
  end

  always_comb begin
    xs     = {{2{s1_x[15]}}, s1_x};
    ys     = {{2{s1_y[15]}}, s1_y};
    w18    = {10'b0, s1_w};
    h18    = {10'b0, s1_h};
    c18    = {10'b0, s1_col};
    xw     = xs + w18;
    yh     = ys + h18;
    col    = s1_flip ? (xw - 18'sd1 - c18) : (xs + c18);
    page   = {s1_y[15], s1_y[15:3]} + {9'b0, s1_row};
    off    = s1_y[2:0];
    en0    = (page >= 14'sd0);
    en1    = (off != 3'd0) && (page < PMAX) && (page >= -14'sd1);
    page_i = int'(page);
    col_i  = int'(col);

    drop = (s1_mode == spb_pkg::MODE_NONE) || (xw < 18'sd0) || (xs > XMAX) ||
           (yh < 18'sd0) || (ys > YMAX) || (s1_col >= s1_w) ||
           ({s1_row, 3'b000} >= s1_h) || (col < 18'sd0) || (col > XMAX) ||
           (page > PMAX) || !(en0 || en1);
    if (s1_op == spb_pkg::OP_READ) begin
      drop = 1'b0;
    end

    q_cmd = '0;
    if (s1_op == spb_pkg::OP_READ) begin
      q_cmd.is_read = 1'b1;
      q_cmd.rd_zero = ({22'b0, s1_raddr} >= 32'(FB_BYTES));
      q_cmd.en0     = 1'b1;
      q_cmd.addr0   = AMW'(s1_raddr);
    end else begin
      q_cmd.mode  = s1_mode;
      q_cmd.en0   = en0;
      q_cmd.en1   = en1;
      q_cmd.bits0 = s1_bits << off;
      q_cmd.bits1 = s1_bits >> (4'd8 - {1'b0, off});
      q_cmd.addr0 = AMW'(page_i * FB_WIDTH + col_i);
      q_cmd.addr1 = AMW'((page_i + 1) * FB_WIDTH + col_i);
    end

    q_push = s1_valid && !drop;
  end

  a_push_has_work: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_cmd.en0 || q_cmd.en1))
    else $error("command queued with no memory access");

endmodule

### rtl/core/spb_back.sv
// Back end: clears the framebuffer after reset, then runs read-modify-write and read commands.
// Depends on spb_pkg, spb_out_if and spb_ram; takes commands from spb_queue.
module spb_back #(
  parameter int FB_WIDTH  = spb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = spb_pkg::FB_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  spb_pkg::spb_cmd_t q_cmd,
  output logic              q_pop,
  output logic              run,
  spb_out_if.source         out_ch
);

  localparam int FB_BYTES = FB_WIDTH * (FB_HEIGHT / 8);
  localparam int AW       = $clog2(FB_BYTES);

  spb_pkg::spb_state_t state;
  spb_pkg::spb_state_t state_next;
  logic [AW-1:0]       clr_cnt;

  logic          phase;
  logic          first;
  logic          issue;
  logic          iss_last;
  logic [AW-1:0] iss_addr;
  logic [7:0]    iss_bits;
  logic          stall;

  logic          w_valid;
  logic          w_is_read;
  logic          w_rd_zero;
  logic [AW-1:0] w_addr;
  logic [7:0]    w_bits;
  logic [1:0]    w_mode;
  logic          fwd_hit;
  logic [7:0]    fwd_data;

  logic [7:0]    rdata;
  logic [7:0]    old_byte;
  logic [7:0]    draw_data;
  logic          draw_we;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  logic          out_valid;
  logic [7:0]    out_data;

  function automatic logic [7:0] merge(logic [7:0] cur, logic [7:0] bits, logic [1:0] mode);
    logic [7:0] res;
    unique case (mode)
      spb_pkg::MODE_OR:  res = cur | bits;
      spb_pkg::MODE_CLR: res = cur & ~bits;
      default:           res = cur ^ bits;
    endcase
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= spb_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == spb_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    run        = 1'b0;
    unique case (state)
      spb_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(FB_BYTES - 1)) begin
          state_next = spb_pkg::ST_RUN;
        end
      end
      spb_pkg::ST_RUN: begin
        run = 1'b1;
      end
    endcase
  end

  assign first    = q_cmd.en0 && !phase;
  assign iss_addr = first ? q_cmd.addr0[AW-1:0] : q_cmd.addr1[AW-1:0];
  assign iss_bits = first ? q_cmd.bits0 : q_cmd.bits1;
  assign iss_last = first ? !q_cmd.en1 : 1'b1;
  assign stall    = w_valid && w_is_read && out_valid && !out_ch.ready;
  assign issue    = run && q_valid && !stall;
  assign q_pop    = issue && iss_last;

  assign old_byte  = fwd_hit ? fwd_data : rdata;
  assign draw_data = merge(old_byte, w_bits, w_mode);
  assign draw_we   = w_valid && !w_is_read;
  assign we        = (state == spb_pkg::ST_CLEAR) || draw_we;
  assign waddr     = (state == spb_pkg::ST_CLEAR) ? clr_cnt : w_addr;
  assign wdata     = (state == spb_pkg::ST_CLEAR) ? 8'h00 : draw_data;

  spb_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (iss_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        phase <= !iss_last;
      end
      if (!stall) begin
        w_valid <= issue;
      end
      if (w_valid && w_is_read && !stall) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w_is_read <= q_cmd.is_read;
      w_rd_zero <= q_cmd.rd_zero;
      w_addr    <= iss_addr;
      w_bits    <= iss_bits;
      w_mode    <= q_cmd.mode;
      fwd_hit   <= draw_we && (w_addr == iss_addr);
      fwd_data  <= draw_data;
    end
    if (w_valid && w_is_read && !stall) begin
      out_data <= w_rd_zero ? 8'h00 : old_byte;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.read_data = out_data;

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == spb_pkg::ST_CLEAR) |-> !issue)
    else $error("command issued during the clearing pass");

  a_second_page_follows: assert property (@(posedge clk) disable iff (rst)
    (issue && !iss_last) |=> phase)
    else $error("second page access of a command was lost");

endmodule

### rtl/core/sprite_page_blitter.sv
// Sprite page blitter top level: APB shift registers, front classifier, queue, memory engine.
// Throughput: one item per cycle for reads and single-page draws while the output is not held
// back; a draw that touches two pages holds the queue head for a second framebuffer access.
// Reset: registers clear at once; the framebuffer is then zeroed, all FB_WIDTH*FB_HEIGHT/8 bytes
// (1024 by default), while input ready stays low. Depends on all files in rtl/core.
module sprite_page_blitter #(
  parameter int FB_WIDTH  = spb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = spb_pkg::FB_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  spb_in_if.sink      in_ch,
  spb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic               run;
  logic               q_push;
  logic               q_ready;
  logic               q_valid;
  logic               q_pop;
  spb_pkg::spb_cmd_t  push_cmd;
  spb_pkg::spb_cmd_t  head_cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x <= '0;
      shift_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        spb_pkg::REG_SHIFT_X: shift_x <= pwdata[15:0];
        spb_pkg::REG_SHIFT_Y: shift_y <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      spb_pkg::REG_SHIFT_X: prdata = {{16{shift_x[15]}}, shift_x};
      spb_pkg::REG_SHIFT_Y: prdata = {{16{shift_y[15]}}, shift_y};
    endcase
  end

  spb_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .run     (run),
    .shift_x (shift_x),
    .shift_y (shift_y),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  spb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  spb_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .run     (run),
    .out_ch  (out_ch)
  );

endmodule
